[src/time_triggered_task_scheduler_assert.svh]
// ----------------------------------------------------------------------------
// Time-triggered task scheduler assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_ASSERT_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the time-triggered task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int DEF_TASK_SLOTS = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int RES_IDX_W      = 3;
	localparam int RES_CNT_W      = 4;

	localparam int SLOT_W   = 7;
	localparam int HANDLE_W = 32;
	localparam int DELAY_W  = 16;
	localparam int COUNT_W  = 8;
	localparam int ERR_W    = 2;
	localparam int FUNC_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [CFG_DATA_W-1:0] DEF_HOLD_TICKS = 32'd60000;

	localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DELETE   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd3;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;
	localparam logic [ERR_W-1:0] ERR_DELETE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_EN   = 1'd1;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [DELAY_W-1:0]  delay;
		logic [DELAY_W-1:0]  period;
		logic [COUNT_W-1:0]  count;
	} slot_ent_t;

	typedef struct packed {
		logic                 en;
		logic [RES_IDX_W-1:0] idx;
		logic [SLOT_W-1:0]    slot;
		logic [HANDLE_W-1:0]  handle;
	} res_wr_t;

	typedef struct packed {
		logic                 en;
		logic [RES_CNT_W-1:0] cnt;
		logic                 ok;
		logic [ERR_W-1:0]     err;
		logic                 idle;
	} res_done_t;

endpackage

[src/tts_slot_mem.sv]
// ----------------------------------------------------------------------------
// tts_slot_mem
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tts_slot_mem #(
	parameter int TASK_SLOTS = tts_pkg::DEF_TASK_SLOTS,
	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [IW-1:0]      rd_addr,
	output tts_pkg::slot_ent_t rd_data,
	input  logic               wr_en,
	input  logic [IW-1:0]      wr_addr,
	input  tts_pkg::slot_ent_t wr_data
);
	import tts_pkg::*;

	slot_ent_t mem_q [TASK_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/tts_ctrl.sv]
// ----------------------------------------------------------------------------
// tts_ctrl
// Command sequencer: slot walk for tick and dispatch, add/delete, error aging.
// ----------------------------------------------------------------------------
`include "time_triggered_task_scheduler_assert.svh"

module tts_ctrl #(
	parameter int TASK_SLOTS = tts_pkg::DEF_TASK_SLOTS,
	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tts_pkg::FUNC_W-1:0]       func,
	input  logic [tts_pkg::DELAY_W-1:0]      first_delay,
	input  logic [tts_pkg::DELAY_W-1:0]      reload_period,
	input  logic [tts_pkg::HANDLE_W-1:0]     task_handle,
	input  logic [tts_pkg::SLOT_W-1:0]       slot_index,
	input  logic                             cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             buf_busy,
	output logic                             mem_rd_en,
	output logic [IW-1:0]                    mem_rd_addr,
	input  tts_pkg::slot_ent_t               mem_rd_data,
	output logic                             mem_wr_en,
	output logic [IW-1:0]                    mem_wr_addr,
	output tts_pkg::slot_ent_t               mem_wr_data,
	output tts_pkg::res_wr_t                 res_wr,
	output tts_pkg::res_done_t               res_done
);
	import tts_pkg::*;

	localparam int CW = $clog2(TASK_SLOTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_AGE  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [FUNC_W-1:0]     func_q;
	logic [CW-1:0]         walk_q;
	logic [RES_CNT_W-1:0]  claim_q;
	logic [TASK_SLOTS-1:0] used_q;
	logic [TASK_SLOTS-1:0] pending_q;
	logic                  ok_q;
	logic [ERR_W-1:0]      sticky_q;
	logic [ERR_W-1:0]      prev_err_q;
	logic [31:0]           since_q;
	logic [31:0]           tick_q;
	logic [CFG_DATA_W-1:0] hold_q;
	logic                  clr_en_q;

	logic                  v_s1;
	logic [IW-1:0]         addr_s1;
	logic [RES_IDX_W-1:0]  ridx_s1;

	logic                  accept;
	logic [IW-1:0]         free_idx;
	logic                  found;
	logic                  add_ok;
	logic                  del_range;
	logic [IW-1:0]         del_idx;
	logic                  del_ok;
	logic [IW-1:0]         walk_idx;
	logic                  walk_end;
	logic                  issue;
	slot_ent_t             ent_new;
	logic                  ovf_s1;
	logic                  drop_s1;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || buf_busy;

	always_comb begin
		free_idx = '0;
		found    = 1'b0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IW'(i);
				found    = 1'b1;
			end
		end
	end

	assign add_ok    = found && (task_handle != '0);
	assign del_range = slot_index < SLOT_W'(TASK_SLOTS);
	assign del_idx   = slot_index[IW-1:0];
	assign del_ok    = del_range && used_q[del_idx];

	assign walk_idx  = walk_q[IW-1:0];
	assign walk_end  = walk_q == CW'(TASK_SLOTS);

	always_comb begin
		issue = 1'b0;
		if (state_q == ST_WALK && !walk_end) begin
			if (func_q == FUNC_TICK) begin
				issue = used_q[walk_idx];
			end else begin
				issue = pending_q[walk_idx] && (claim_q < RES_CNT_W'(MAX_RESULTS));
			end
		end
	end

	assign mem_rd_en   = issue;
	assign mem_rd_addr = walk_idx;

	// read-modify of the slot fetched last cycle
	always_comb begin
		ent_new = mem_rd_data;
		ovf_s1  = 1'b0;
		drop_s1 = 1'b0;
		if (func_q == FUNC_TICK) begin
			if (mem_rd_data.delay == '0) begin
				if (mem_rd_data.count != COUNT_MAX) begin
					ent_new.count = mem_rd_data.count + COUNT_W'(1);
				end else begin
					ovf_s1 = 1'b1;
				end
				if (mem_rd_data.period != '0) begin
					ent_new.delay = mem_rd_data.period;
				end
			end else begin
				ent_new.delay = mem_rd_data.delay - DELAY_W'(1);
			end
		end else begin
			ent_new.count = mem_rd_data.count - COUNT_W'(1);
			drop_s1       = mem_rd_data.period == '0;
		end
	end

	always_comb begin
		if (v_s1) begin
			mem_wr_en   = !drop_s1;
			mem_wr_addr = addr_s1;
			mem_wr_data = ent_new;
		end else begin
			mem_wr_en          = accept && (func == FUNC_ADD) && add_ok;
			mem_wr_addr        = free_idx;
			mem_wr_data.handle = task_handle;
			mem_wr_data.delay  = first_delay;
			mem_wr_data.period = reload_period;
			mem_wr_data.count  = '0;
		end
	end

	always_comb begin
		res_wr.en = accept || (v_s1 && func_q == FUNC_DISPATCH);
		if (v_s1) begin
			res_wr.idx    = ridx_s1;
			res_wr.slot   = SLOT_W'(addr_s1);
			res_wr.handle = mem_rd_data.handle;
		end else begin
			res_wr.idx    = '0;
			res_wr.slot   = (func == FUNC_ADD && add_ok) ? SLOT_W'(free_idx)
				: SLOT_W'(TASK_SLOTS);
			res_wr.handle = '0;
		end
	end

	always_comb begin
		res_done.en   = state_q == ST_FIN;
		res_done.cnt  = (claim_q == '0) ? RES_CNT_W'(1) : claim_q;
		res_done.ok   = ok_q;
		res_done.err  = sticky_q;
		res_done.idle = ~|pending_q;
	end

	always_ff @(posedge clk) begin
		addr_s1 <= walk_idx;
		ridx_s1 <= claim_q[RES_IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			func_q     <= FUNC_TICK;
			walk_q     <= '0;
			claim_q    <= '0;
			used_q     <= '0;
			pending_q  <= '0;
			ok_q       <= 1'b0;
			sticky_q   <= ERR_NONE;
			prev_err_q <= ERR_NONE;
			since_q    <= '0;
			tick_q     <= '0;
			hold_q     <= DEF_HOLD_TICKS;
			clr_en_q   <= 1'b1;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= issue;

			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_TICKS: hold_q <= cfg_data;
					REG_CLEAR_EN:   clr_en_q <= cfg_data[0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q  <= func;
						walk_q  <= '0;
						claim_q <= '0;
						ok_q    <= 1'b1;
						case (func)
							FUNC_TICK: begin
								tick_q  <= tick_q + 32'd1;
								state_q <= ST_WALK;
							end
							FUNC_ADD: begin
								if (add_ok) begin
									used_q[free_idx] <= 1'b1;
								end else begin
									sticky_q <= ERR_FULL;
									ok_q     <= 1'b0;
								end
								state_q <= ST_FIN;
							end
							FUNC_DELETE: begin
								if (del_range) begin
									used_q[del_idx]    <= 1'b0;
									pending_q[del_idx] <= 1'b0;
								end
								if (!del_ok) begin
									sticky_q <= ERR_DELETE;
									ok_q     <= 1'b0;
								end
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_WALK;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (!walk_end) begin
						walk_q <= walk_q + CW'(1);
					end
					if (issue && func_q == FUNC_DISPATCH) begin
						claim_q <= claim_q + RES_CNT_W'(1);
					end
					if (walk_end) begin
						state_q <= (func_q == FUNC_DISPATCH) ? ST_AGE : ST_FIN;
					end
				end
				ST_AGE: begin
					if (clr_en_q) begin
						if (sticky_q != prev_err_q) begin
							prev_err_q <= sticky_q;
							since_q    <= tick_q;
						end else if (sticky_q != ERR_NONE &&
							(tick_q - since_q) >= hold_q) begin
							sticky_q   <= ERR_NONE;
							prev_err_q <= ERR_NONE;
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (v_s1) begin
				if (func_q == FUNC_TICK) begin
					pending_q[addr_s1] <= ent_new.count != '0;
					if (ovf_s1) begin
						sticky_q <= ERR_OVERFLOW;
					end
				end else if (drop_s1) begin
					used_q[addr_s1]    <= 1'b0;
					pending_q[addr_s1] <= 1'b0;
				end else begin
					pending_q[addr_s1] <= ent_new.count != '0;
				end
			end
		end
	end

	`TTS_ASSERT_IMP(a_pending_used, clk, arst_n, 1'b1, (pending_q & ~used_q) == '0, "pending run on a free slot")
	`TTS_ASSERT_IMP(a_claim_limit, clk, arst_n, 1'b1, claim_q <= RES_CNT_W'(MAX_RESULTS), "too many claims in one pass")
	`TTS_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE, "accepted item not in work")

endmodule

[src/tts_result_buf.sv]
// ----------------------------------------------------------------------------
// tts_result_buf
// Holds the results of one item and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
`include "time_triggered_task_scheduler_assert.svh"

module tts_result_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tts_pkg::res_wr_t              res_wr,
	input  tts_pkg::res_done_t            res_done,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tts_pkg::SLOT_W-1:0]    slot_index_res,
	output logic [tts_pkg::HANDLE_W-1:0]  task_handle_res,
	output logic                          ok,
	output logic [tts_pkg::ERR_W-1:0]     error_code,
	output logic                          all_idle,
	output logic                          last
);
	import tts_pkg::*;

	logic [SLOT_W-1:0]    slot_q   [MAX_RESULTS];
	logic [HANDLE_W-1:0]  handle_q [MAX_RESULTS];
	logic                 busy_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_IDX_W-1:0] rd_q;
	logic                 ok_q;
	logic [ERR_W-1:0]     err_q;
	logic                 idle_q;
	logic                 xfer;

	assign busy            = busy_q;
	assign out_valid       = busy_q;
	assign xfer            = busy_q && !out_stall;
	assign slot_index_res  = slot_q[rd_q];
	assign task_handle_res = handle_q[rd_q];
	assign ok              = ok_q;
	assign error_code      = err_q;
	assign all_idle        = idle_q;
	assign last            = {1'b0, rd_q} == (cnt_q - RES_CNT_W'(1));

	always_ff @(posedge clk) begin
		if (res_wr.en) begin
			slot_q[res_wr.idx]   <= res_wr.slot;
			handle_q[res_wr.idx] <= res_wr.handle;
		end
		if (res_done.en) begin
			cnt_q  <= res_done.cnt;
			ok_q   <= res_done.ok;
			err_q  <= res_done.err;
			idle_q <= res_done.idle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q   <= '0;
		end else begin
			if (res_done.en) begin
				busy_q <= 1'b1;
				rd_q   <= '0;
			end else if (xfer) begin
				if (last) begin
					busy_q <= 1'b0;
					rd_q   <= '0;
				end else begin
					rd_q <= rd_q + RES_IDX_W'(1);
				end
			end
		end
	end

	`TTS_ASSERT_IMP(a_rd_in_range, clk, arst_n, busy_q, {1'b0, rd_q} < cnt_q, "read pointer past result count")
	`TTS_ASSERT_IMP(a_wr_when_free, clk, arst_n, res_wr.en || res_done.en, !busy_q, "results written while draining")
	`TTS_ASSERT_IMP(a_done_cnt, clk, arst_n, res_done.en, (res_done.cnt != '0) && (res_done.cnt <= RES_CNT_W'(MAX_RESULTS)), "bad result count")

endmodule

[src/time_triggered_task_scheduler.sv]
// Add and delete give their result without a walk; a tick and a dispatch pass walk the
// slot table one slot per cycle. Throughput: one item at a time; the next item is taken
// the cycle after its last result transfer; the single read port sets the walk.
// Reset: asynchronous; all slots empty at once through per-slot used bits, no clearing pass.
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler
// Slot-table scheduler: tick, add, delete and dispatch over a slot memory.
// ----------------------------------------------------------------------------
module time_triggered_task_scheduler #(
	parameter int TASK_SLOTS = tts_pkg::DEF_TASK_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tts_pkg::FUNC_W-1:0]     func,
	input  logic [tts_pkg::DELAY_W-1:0]    first_delay,
	input  logic [tts_pkg::DELAY_W-1:0]    reload_period,
	input  logic [tts_pkg::HANDLE_W-1:0]   task_handle,
	input  logic [tts_pkg::SLOT_W-1:0]     slot_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tts_pkg::SLOT_W-1:0]     slot_index_res,
	output logic [tts_pkg::HANDLE_W-1:0]   task_handle_res,
	output logic                           ok,
	output logic [tts_pkg::ERR_W-1:0]      error_code,
	output logic                           all_idle,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tts_pkg::*;

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	logic          buf_busy;
	logic          mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	slot_ent_t     mem_rd_data;
	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	slot_ent_t     mem_wr_data;
	res_wr_t       res_wr;
	res_done_t     res_done;

	tts_ctrl #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.first_delay   (first_delay),
		.reload_period (reload_period),
		.task_handle   (task_handle),
		.slot_index    (slot_index),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.buf_busy      (buf_busy),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.res_wr        (res_wr),
		.res_done      (res_done)
	);

	tts_slot_mem #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	tts_result_buf u_res (
		.clk             (clk),
		.arst_n          (arst_n),
		.res_wr          (res_wr),
		.res_done        (res_done),
		.busy            (buf_busy),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.slot_index_res  (slot_index_res),
		.task_handle_res (task_handle_res),
		.ok              (ok),
		.error_code      (error_code),
		.all_idle        (all_idle),
		.last            (last)
	);

endmodule

[test/time_triggered_task_scheduler_checker.sv]
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler_checker
// Watches the input, result and register ports of the scheduler, keeps its
// own copy of the slot table and error aging, predicts the results of every
// accepted transfer and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module time_triggered_task_scheduler_checker #(
	parameter int TASK_SLOTS = tts_pkg::DEF_TASK_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [tts_pkg::FUNC_W-1:0]     func,
	input  logic [tts_pkg::DELAY_W-1:0]    first_delay,
	input  logic [tts_pkg::DELAY_W-1:0]    reload_period,
	input  logic [tts_pkg::HANDLE_W-1:0]   task_handle,
	input  logic [tts_pkg::SLOT_W-1:0]     slot_index,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [tts_pkg::SLOT_W-1:0]     slot_index_res,
	input  logic [tts_pkg::HANDLE_W-1:0]   task_handle_res,
	input  logic                           ok,
	input  logic [tts_pkg::ERR_W-1:0]      error_code,
	input  logic                           all_idle,
	input  logic                           last,
	input  logic                           cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             failures,
	output int                             owed
);
	import tts_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle;
		logic                ok;
		logic [ERR_W-1:0]    err;
		logic                idle;
		logic                last;
	} sched_result_t;

	localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(TASK_SLOTS);

	logic [HANDLE_W-1:0]   handles [TASK_SLOTS];
	logic [DELAY_W-1:0]    delays  [TASK_SLOTS];
	logic [DELAY_W-1:0]    periods [TASK_SLOTS];
	logic [COUNT_W-1:0]    runs    [TASK_SLOTS];
	logic [ERR_W-1:0]      sticky;
	logic [ERR_W-1:0]      prev_err;
	logic [31:0]           ticks;
	logic [31:0]           err_since;
	logic [CFG_DATA_W-1:0] hold_ticks;
	logic                  aging_on;

	sched_result_t owed_results[$];

	function automatic sched_result_t outcome(logic [SLOT_W-1:0] slot,
			logic [HANDLE_W-1:0] handle, logic okv);
		sched_result_t r;
		r = '0;
		r.slot = slot;
		r.handle = handle;
		r.ok = okv;
		return r;
	endfunction

	task automatic free_slot(int s);
		handles[s] = '0;
		delays[s] = '0;
		periods[s] = '0;
		runs[s] = '0;
	endtask

	task automatic reset_table();
		for (int s = 0; s < TASK_SLOTS; s++)
			free_slot(s);
		sticky = ERR_NONE;
		prev_err = ERR_NONE;
		ticks = '0;
		err_since = '0;
		hold_ticks = DEF_HOLD_TICKS;
		aging_on = 1'b1;
	endtask

	task automatic schedule_item(logic [FUNC_W-1:0] f, logic [DELAY_W-1:0] d,
			logic [DELAY_W-1:0] p, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] si);
		sched_result_t batch[$];
		sched_result_t r;
		int s;
		bit busy;
		busy = 1'b0;
		case (f)
		FUNC_TICK: begin
			ticks = ticks + 32'd1;
			for (s = 0; s < TASK_SLOTS; s++) begin
				if (handles[s] != '0) begin
					if (delays[s] == '0) begin
						if (runs[s] != COUNT_MAX)
							runs[s] = runs[s] + COUNT_W'(1);
						else
							sticky = ERR_OVERFLOW;
						if (periods[s] != '0)
							delays[s] = periods[s];
					end else begin
						delays[s] = delays[s] - DELAY_W'(1);
					end
				end
			end
			batch.push_back(outcome(NO_SLOT, '0, 1'b1));
		end
		FUNC_ADD: begin
			s = 0;
			while (s < TASK_SLOTS && handles[s] != '0)
				s++;
			if (s >= TASK_SLOTS || h == '0) begin
				sticky = ERR_FULL;
				batch.push_back(outcome(NO_SLOT, '0, 1'b0));
			end else begin
				delays[s] = d;
				periods[s] = p;
				runs[s] = '0;
				handles[s] = h;
				batch.push_back(outcome(SLOT_W'(s), '0, 1'b1));
			end
		end
		FUNC_DELETE: begin
			if (si >= TASK_SLOTS) begin
				sticky = ERR_DELETE;
				batch.push_back(outcome(NO_SLOT, '0, 1'b0));
			end else if (handles[si] == '0) begin
				sticky = ERR_DELETE;
				free_slot(si);
				batch.push_back(outcome(NO_SLOT, '0, 1'b0));
			end else begin
				free_slot(si);
				batch.push_back(outcome(NO_SLOT, '0, 1'b1));
			end
		end
		FUNC_DISPATCH: begin
			for (s = 0; s < TASK_SLOTS && batch.size() < MAX_RESULTS; s++) begin
				if (handles[s] != '0 && runs[s] != '0) begin
					batch.push_back(outcome(SLOT_W'(s), handles[s], 1'b1));
					runs[s] = runs[s] - COUNT_W'(1);
					if (periods[s] == '0)
						free_slot(s);
				end
			end
			if (batch.size() == 0)
				batch.push_back(outcome(NO_SLOT, '0, 1'b1));
			if (aging_on) begin
				if (sticky != prev_err) begin
					prev_err = sticky;
					err_since = ticks;
				end else if (sticky != ERR_NONE && (ticks - err_since) >= hold_ticks) begin
					sticky = ERR_NONE;
					prev_err = ERR_NONE;
				end
			end
		end
		endcase
		for (s = 0; s < TASK_SLOTS; s++)
			if (runs[s] != '0)
				busy = 1'b1;
		for (int k = 0; k < batch.size(); k++) begin
			r = batch[k];
			r.err = sticky;
			r.idle = !busy;
			r.last = (k == batch.size() - 1);
			owed_results.push_back(r);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_result();
		sched_result_t want;
		if (owed_results.size() == 0) begin
			$error("result transfer with nothing expected, slot_index_res %0d", slot_index_res);
			failures++;
		end else begin
			want = owed_results.pop_front();
			check_field("slot_index_res", want.slot, slot_index_res);
			check_field("task_handle_res", want.handle, task_handle_res);
			check_field("ok", want.ok, ok);
			check_field("error_code", want.err, error_code);
			check_field("all_idle", want.idle, all_idle);
			check_field("last", want.last, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_table();
			owed_results.delete();
			failures = 0;
			owed = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_we) begin
				if (cfg_index == REG_HOLD_TICKS)
					hold_ticks = cfg_data;
				else if (cfg_index == REG_CLEAR_EN)
					aging_on = cfg_data[0];
			end
			if (in_valid && !in_stall)
				schedule_item(func, first_delay, reload_period, task_handle, slot_index);
			owed = owed_results.size();
		end
	end

endmodule

[test/time_triggered_task_scheduler_test.sv]
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler_test
// Drives the scheduler with a directed sequence (empty table, bad adds and
// deletes, full table, a full dispatch pass) and four random phases with
// different idling, stalling and register settings. The checker beside the
// block predicts and compares results.
// ----------------------------------------------------------------------------
module time_triggered_task_scheduler_test;
	import tts_pkg::*;

	localparam int SLOTS    = DEF_TASK_SLOTS;
	localparam int WATCHDOG = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [FUNC_W-1:0]     func;
	logic [DELAY_W-1:0]    first_delay;
	logic [DELAY_W-1:0]    reload_period;
	logic [HANDLE_W-1:0]   task_handle;
	logic [SLOT_W-1:0]     slot_index;
	logic                  out_valid;
	logic                  out_stall;
	logic [SLOT_W-1:0]     slot_index_res;
	logic [HANDLE_W-1:0]   task_handle_res;
	logic                  ok;
	logic [ERR_W-1:0]      error_code;
	logic                  all_idle;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int failures;
	int owed;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int quiet;

	time_triggered_task_scheduler #(.TASK_SLOTS(SLOTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .first_delay(first_delay), .reload_period(reload_period),
		.task_handle(task_handle), .slot_index(slot_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_index_res(slot_index_res), .task_handle_res(task_handle_res),
		.ok(ok), .error_code(error_code), .all_idle(all_idle), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	time_triggered_task_scheduler_checker #(.TASK_SLOTS(SLOTS)) sched_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .first_delay(first_delay), .reload_period(reload_period),
		.task_handle(task_handle), .slot_index(slot_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_index_res(slot_index_res), .task_handle_res(task_handle_res),
		.ok(ok), .error_code(error_code), .all_idle(all_idle), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .owed(owed)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver: long hold-off when requested, else random stall
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG) begin
			$display("time_triggered_task_scheduler: mismatch");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// starts and returns at a rising edge; returns at the edge of the transfer
	task automatic offer(logic [FUNC_W-1:0] f, logic [DELAY_W-1:0] d,
			logic [DELAY_W-1:0] p, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] si);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		first_delay <= d;
		reload_period <= p;
		task_handle <= h;
		slot_index <= si;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_DATA_W-1:0] hold, logic en);
		cfg_we <= 1'b1;
		cfg_index <= REG_HOLD_TICKS;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= REG_CLEAR_EN;
		cfg_data <= {{(CFG_DATA_W-1){1'b0}}, en};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int pick;
		logic [FUNC_W-1:0]   f;
		logic [DELAY_W-1:0]  d;
		logic [DELAY_W-1:0]  p;
		logic [HANDLE_W-1:0] h;
		logic [SLOT_W-1:0]   si;
		pick = $urandom_range(99);
		if (pick < 45)
			f = FUNC_TICK;
		else if (pick < 65)
			f = FUNC_ADD;
		else if (pick < 77)
			f = FUNC_DELETE;
		else
			f = FUNC_DISPATCH;
		h = $urandom();
		if ($urandom_range(19) == 0)
			h = '0;
		d = ($urandom_range(9) == 0) ? DELAY_W'($urandom()) : DELAY_W'($urandom_range(4));
		pick = $urandom_range(9);
		if (pick < 3)
			p = '0;
		else if (pick < 9)
			p = DELAY_W'($urandom_range(4, 1));
		else
			p = DELAY_W'($urandom());
		si = ($urandom_range(9) == 0) ? SLOT_W'($urandom()) : SLOT_W'($urandom_range(SLOTS - 1));
		offer(f, d, p, h, si);
	endtask

	initial begin
		in_valid = 1'b0;
		func = FUNC_TICK;
		first_delay = '0;
		reload_period = '0;
		task_handle = '0;
		slot_index = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HOLD_TICKS;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, bad adds and deletes, full table, full dispatch pass
		offer(FUNC_DISPATCH, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_TICK, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_ADD, 16'd3, 16'd3, 32'd0, 7'd0);
		offer(FUNC_DELETE, 16'd0, 16'd0, 32'd0, 7'd127);
		offer(FUNC_DELETE, 16'd0, 16'd0, 32'd0, 7'd3);
		offer(FUNC_ADD, 16'd0, 16'd0, 32'hFFFF_FFFF, 7'd0);
		offer(FUNC_ADD, 16'd0, 16'hFFFF, 32'd1, 7'd0);
		offer(FUNC_ADD, 16'd0, 16'd1, 32'hA5A5_5A5A, 7'd0);
		repeat (5)
			offer(FUNC_ADD, 16'd0, 16'd2, $urandom() | 32'd1, 7'd0);
		offer(FUNC_ADD, 16'd0, 16'd0, 32'h123, 7'd0);
		offer(FUNC_TICK, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_TICK, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_DISPATCH, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_DELETE, 16'd0, 16'd0, 32'd0, 7'd1);
		offer(FUNC_ADD, 16'hFFFF, 16'hFFFF, 32'd2, 7'd0);
		offer(FUNC_DELETE, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_TICK, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_DISPATCH, 16'd0, 16'd0, 32'd0, 7'd0);
		offer(FUNC_DISPATCH, 16'd0, 16'd0, 32'd0, 7'd0);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
				set_regs(32'd0, 1'b1);
				hold_cycles = 300;
			end
			1: begin
				send_idle_pct = 68;
				stall_pct = 0;
				set_regs(32'hFFFF_FFFF, 1'b1);
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 68;
				set_regs(32'd5, 1'b0);
			end
			default: begin
				send_idle_pct = 33;
				stall_pct = 33;
				set_regs(32'd2, 1'b1);
			end
			endcase
			repeat (62)
				random_item();
			settle();
		end

		repeat (SLOTS + 8) @(posedge clk);
		if (failures == 0 && owed == 0)
			$display("time_triggered_task_scheduler: match");
		else
			$display("time_triggered_task_scheduler: mismatch");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/tts_pkg.sv
src/tts_slot_mem.sv
src/tts_ctrl.sv
src/tts_result_buf.sv
src/time_triggered_task_scheduler.sv
test/time_triggered_task_scheduler_checker.sv
test/time_triggered_task_scheduler_test.sv
